// ----- rtl/core/ride_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ride_pkg
// Shared types, opcodes and character constants of the radix digit emitter.
// ----------------------------------------------------------------------------
package ride_pkg;

    localparam int OPCODE_W = 3;
    localparam int CHAR_W   = 7;
    localparam int DIGIT_W  = 4;

    localparam logic [OPCODE_W-1:0] OP_BIN   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_OCT   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_HEX   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_DEC   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FIXED = 3'd4;

    // Digit width selects of the shifter
    localparam logic [1:0] DSEL_BIN = 2'd0;
    localparam logic [1:0] DSEL_OCT = 2'd1;
    localparam logic [1:0] DSEL_HEX = 2'd2;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO        = 7'd48;
    localparam logic [CHAR_W-1:0]  HEX_LETTER_OFFSET = 7'd55;
    localparam logic [DIGIT_W-1:0] DEC_RADIX         = 4'd10;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT     = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD       = 4'd3;

    typedef struct packed {
        logic                busy;
        logic                valid;
        logic [DIGIT_W-1:0]  digit;
        logic                last;
    } shift_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } bcd_stat_t;

    function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        return (d < DEC_RADIX) ? (dx + ASCII_ZERO) : (dx + HEX_LETTER_OFFSET);
    endfunction

endpackage

// ----- rtl/core/ride_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ride_req_if
// Request channel: one signed integer and an opcode per transfer.
// ----------------------------------------------------------------------------
interface ride_req_if #(
    parameter int VALUE_WIDTH = 32
);
    import ride_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [OPCODE_W-1:0]           opcode;

    modport source (output valid, output value, output opcode, input ready);
    modport sink   (input valid, input value, input opcode, output ready);

endinterface

// ----- rtl/core/ride_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ride_res_if
// Result channel: one digit character per transfer, last and error flags.
// ----------------------------------------------------------------------------
interface ride_res_if;
    import ride_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  char_code;
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               error;

    modport source (output valid, output char_code, output digit, output last,
                    output error, input ready);
    modport sink   (input valid, input char_code, input digit, input last,
                    input error, output ready);

endinterface

// ----- rtl/core/ride_bcd_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ride_bcd_conv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
module ride_bcd_conv #(
    parameter int VALUE_WIDTH = 32,
    parameter int NUM_DIGITS  = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [VALUE_WIDTH-1:0]      value,
    output ride_pkg::bcd_stat_t         stat,
    output logic [4*NUM_DIGITS-1:0]     bcd
);
    import ride_pkg::*;

    localparam int BW  = 4 * NUM_DIGITS;
    localparam int CNW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BW-1:0]          bcd_reg, bcd_next;
    logic [CNW-1:0]         cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [BW-1:0]          bcd_adj;

    // Add 3 to every nibble that is 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= BCD_ADJ_LIMIT)
                              ? (bcd_reg[4*i +: 4] + BCD_ADJ_ADD)
                              : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = CNW'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BW-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = bin_reg << 1;
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule

// ----- rtl/core/ride_digit_shifter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ride_digit_shifter
// Digit shift register: drops leading zero digits when load_skip is set, then
// presents one digit per step, most significant first.
// ----------------------------------------------------------------------------
module ride_digit_shifter #(
    parameter int SHW = 36,
    parameter int CW  = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic [SHW-1:0]          load_data,
    input  logic [1:0]              load_dsel,
    input  logic [CW-1:0]           load_count,
    input  logic                    load_skip,
    input  logic                    step,
    output ride_pkg::shift_stat_t   stat
);
    import ride_pkg::*;

    logic [SHW-1:0]     data_reg, data_next;
    logic [1:0]         dsel_reg, dsel_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               skip_reg, skip_next;
    logic               busy_reg, busy_next;
    logic [DIGIT_W-1:0] top_digit;
    logic [SHW-1:0]     shifted;
    logic               skipping;

    always_comb
    begin
        case (dsel_reg)
            DSEL_BIN:
            begin
                top_digit = {3'b000, data_reg[SHW-1]};
                shifted   = data_reg << 1;
            end
            DSEL_OCT:
            begin
                top_digit = {1'b0, data_reg[SHW-1 -: 3]};
                shifted   = data_reg << 3;
            end
            default:
            begin
                top_digit = data_reg[SHW-1 -: 4];
                shifted   = data_reg << 4;
            end
        endcase
    end

    // Keep one digit at least so that zero still gives a single '0'
    assign skipping = busy_reg && skip_reg && (top_digit == '0) &&
                      (count_reg > CW'(1));

    always_comb
    begin
        data_next  = data_reg;
        dsel_next  = dsel_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        busy_next  = busy_reg;
        if (load)
        begin
            data_next  = load_data;
            dsel_next  = load_dsel;
            count_next = load_count;
            skip_next  = load_skip;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (skipping)
            begin
                data_next  = shifted;
                count_next = count_reg - CW'(1);
            end
            else
            begin
                skip_next = 1'b0;
                if (step)
                begin
                    data_next  = shifted;
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsel_reg  <= DSEL_BIN;
            count_reg <= '0;
            skip_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            dsel_reg  <= dsel_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign stat.busy  = busy_reg;
    assign stat.valid = busy_reg && !skipping;
    assign stat.digit = top_digit;
    assign stat.last  = (count_reg == CW'(1));

endmodule

// ----- rtl/core/integer_radix_digit_emitter_top.sv -----
`timescale 1ns / 1ps
// Sequence: radix modes load the shifter, drop leading zeros, then emit one digit
// per step while the output register is free; decimal first runs a bit-serial BCD
// conversion; the fixed mode emits FIXED_BITS binary digits without zero dropping.
// Throughput: one item at a time; the next item is taken once the shifter is idle
// and the FSM is back in idle (after an error, once the error result is written).
// Reset: rst_n clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
// integer_radix_digit_emitter_top
// Emits the binary, octal, hex, decimal or fixed-width digits of an integer.
// ----------------------------------------------------------------------------
module integer_radix_digit_emitter_top #(
    parameter int VALUE_WIDTH = 32,
    parameter int FIXED_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ride_req_if.sink    request,
    ride_res_if.source  result
);
    import ride_pkg::*;

    localparam int NUM_DEC = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int RAW_A   = (VALUE_WIDTH > 4 * NUM_DEC) ? VALUE_WIDTH : 4 * NUM_DEC;
    localparam int RAW_W   = (RAW_A > FIXED_BITS) ? RAW_A : FIXED_BITS;
    localparam int SHW     = ((RAW_W + 11) / 12) * 12;
    localparam int CW      = $clog2(SHW + 1);
    localparam int EXT_W   = (VALUE_WIDTH > FIXED_BITS) ? VALUE_WIDTH : FIXED_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BCD  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               res_valid_reg, res_valid_next;
    logic [CHAR_W-1:0]  res_char_reg, res_char_next;
    logic [DIGIT_W-1:0] res_digit_reg, res_digit_next;
    logic               res_last_reg, res_last_next;
    logic               res_error_reg, res_error_next;

    logic                    accept;
    logic                    res_free;
    logic                    negative;
    logic [VALUE_WIDTH-1:0]  value_u;
    logic [EXT_W-1:0]        value_ext;
    logic                    bcd_start;
    bcd_stat_t               bcd_stat;
    logic [4*NUM_DEC-1:0]    bcd_data;
    logic                    sh_load;
    logic [SHW-1:0]          sh_data;
    logic [1:0]              sh_dsel;
    logic [CW-1:0]           sh_count;
    logic                    sh_skip;
    logic                    sh_step;
    shift_stat_t             sh_stat;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign res_free      = !res_valid_reg || result.ready;
    assign value_u       = $unsigned(request.value);
    assign value_ext     = EXT_W'(value_u);
    assign negative      = value_u[VALUE_WIDTH-1];

    ride_bcd_conv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DEC)
    ) u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .value (value_u),
        .stat  (bcd_stat),
        .bcd   (bcd_data)
    );

    ride_digit_shifter #(
        .SHW (SHW),
        .CW  (CW)
    ) u_shift (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (sh_load),
        .load_data  (sh_data),
        .load_dsel  (sh_dsel),
        .load_count (sh_count),
        .load_skip  (sh_skip),
        .step       (sh_step),
        .stat       (sh_stat)
    );

    assign sh_step = (state_reg == ST_RUN) && sh_stat.valid && res_free;

    always_comb
    begin
        state_next = state_reg;
        bcd_start  = 1'b0;
        sh_load    = 1'b0;
        sh_data    = SHW'(value_u);
        sh_dsel    = DSEL_HEX;
        sh_count   = CW'(SHW / 4);
        sh_skip    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.opcode == OP_FIXED)
                    begin
                        sh_load    = 1'b1;
                        sh_data    = SHW'(value_ext[FIXED_BITS-1:0]) << (SHW - FIXED_BITS);
                        sh_dsel    = DSEL_BIN;
                        sh_count   = CW'(FIXED_BITS);
                        sh_skip    = 1'b0;
                        state_next = ST_RUN;
                    end
                    else if (request.opcode > OP_FIXED || negative)
                    begin
                        state_next = ST_ERR;
                    end
                    else if (request.opcode == OP_DEC)
                    begin
                        bcd_start  = 1'b1;
                        state_next = ST_BCD;
                    end
                    else
                    begin
                        sh_load    = 1'b1;
                        state_next = ST_RUN;
                        case (request.opcode)
                            OP_BIN:
                            begin
                                sh_dsel  = DSEL_BIN;
                                sh_count = CW'(SHW);
                            end
                            OP_OCT:
                            begin
                                sh_dsel  = DSEL_OCT;
                                sh_count = CW'(SHW / 3);
                            end
                            default:
                            begin
                                sh_dsel  = DSEL_HEX;
                                sh_count = CW'(SHW / 4);
                            end
                        endcase
                    end
                end
            end
            ST_BCD:
            begin
                if (bcd_stat.done)
                begin
                    sh_load    = 1'b1;
                    sh_data    = SHW'(bcd_data);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!sh_stat.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: hold until the sink takes the transfer
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_char_next  = res_char_reg;
        res_digit_next = res_digit_reg;
        res_last_next  = res_last_reg;
        res_error_next = res_error_reg;
        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (sh_step)
        begin
            res_valid_next = 1'b1;
            res_char_next  = char_of(sh_stat.digit);
            res_digit_next = sh_stat.digit;
            res_last_next  = sh_stat.last;
            res_error_next = 1'b0;
        end
        else if ((state_reg == ST_ERR) && res_free)
        begin
            res_valid_next = 1'b1;
            res_char_next  = '0;
            res_digit_next = '0;
            res_last_next  = 1'b1;
            res_error_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_char_reg  <= res_char_next;
        res_digit_reg <= res_digit_next;
        res_last_reg  <= res_last_next;
        res_error_reg <= res_error_next;
    end

    assign result.valid     = res_valid_reg;
    assign result.char_code = res_char_reg;
    assign result.digit     = res_digit_reg;
    assign result.last      = res_last_reg;
    assign result.error     = res_error_reg;

endmodule
